// File: design/aabbtt_pkg.sv
// Package for the tile bounding-box table: box and entry types, op and status
// codes, controller states and the default table depth. No dependencies.
`timescale 1ns / 1ps

package aabbtt_pkg;

  localparam int DEFAULT_MAX_TILES = 64;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_BUFFERED  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  typedef struct packed {
    logic [15:0] key;
    box_t        box;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

// File: design/aabbtt_box_unit.sv
// Box arithmetic for the tile table: grows the pending box by one vertex and
// tests a point against a stored box. Depends on aabbtt_pkg.
`timescale 1ns / 1ps

module aabbtt_box_unit
  import aabbtt_pkg::*;
(
  input  coord_t vx,
  input  coord_t vy,
  input  coord_t vz,
  input  box_t   pend,
  input  logic   pend_active,
  output box_t   merged,
  input  coord_t qx,
  input  coord_t qy,
  input  coord_t qz,
  input  box_t   cand,
  output logic   holds
);

  // A fresh tile starts as the single point of its first vertex.
  always_comb begin
    if (!pend_active) begin
      merged = '{lo_x: vx, lo_y: vy, lo_z: vz, hi_x: vx, hi_y: vy, hi_z: vz};
    end else begin
      merged.lo_x = (vx < pend.lo_x) ? vx : pend.lo_x;
      merged.lo_y = (vy < pend.lo_y) ? vy : pend.lo_y;
      merged.lo_z = (vz < pend.lo_z) ? vz : pend.lo_z;
      merged.hi_x = (vx > pend.hi_x) ? vx : pend.hi_x;
      merged.hi_y = (vy > pend.hi_y) ? vy : pend.hi_y;
      merged.hi_z = (vz > pend.hi_z) ? vz : pend.hi_z;
    end
  end

  // Inclusive bounds on every axis.
  assign holds = (qx >= cand.lo_x) && (qx <= cand.hi_x) &&
                 (qy >= cand.lo_y) && (qy <= cand.hi_y) &&
                 (qz >= cand.lo_z) && (qz <= cand.hi_z);

endmodule

// File: design/aabb_tile_table_point_lookup_core.sv
// Top level of the tile bounding-box table with point lookup.
// Depends on aabbtt_pkg and aabbtt_box_unit.
`timescale 1ns / 1ps

// Usage:
// A word is offered on op, tile_key, coord_x/y/z and last_vertex with start
// high; it is taken at a rising edge where start is high and busy is low.
// Each word produces exactly one result word on status, hit and found_key,
// shown for a single cycle with done high. The receiver cannot stall, so
// a result is taken in the cycle it appears.
// An add vertex that is not the last, and an unused op, answer in the cycle
// after acceptance and leave busy low, so the next word may follow at once.
// A last vertex, a remove and a query walk the table through the one read
// port of the entry memory, one entry per cycle; a remove that hits moves
// every later entry down by one as the walk goes on. busy stays high for
// the whole walk.
// Reset clears the tile count and the pending tile; the entry memory needs
// no clearing, because only entries below the count are ever read.
// Tiles are kept in insertion order, so a query returns the oldest tile
// whose box holds the point.

module aabb_tile_table_point_lookup_core
  import aabbtt_pkg::*;
#(
  parameter int MAX_TILES = DEFAULT_MAX_TILES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [15:0] tile_key,
  input  coord_t      coord_x,
  input  coord_t      coord_y,
  input  coord_t      coord_z,
  input  logic        last_vertex,
  output logic        done,
  output logic [2:0]  status,
  output logic        hit,
  output logic [15:0] found_key
);

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW = $clog2(MAX_TILES + 1);

  state_t state, state_next;

  // Entry memory: key and box per tile, synchronous read.
  entry_t mem [MAX_TILES];
  entry_t rd_data;
  logic   rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan_idx;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic          scan_more;

  logic [1:0]  op_q;
  logic [15:0] key_q;
  coord_t      px, py, pz;
  box_t        box_q;
  box_t        pend_box;
  logic        pend_active;
  box_t        merged;
  logic        holds, match;

  logic        accept;
  logic        done_next, hit_next;
  logic [2:0]  status_next;
  logic [15:0] key_next;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  aabbtt_box_unit u_box (
    .vx          (coord_x),
    .vy          (coord_y),
    .vz          (coord_z),
    .pend        (pend_box),
    .pend_active (pend_active),
    .merged      (merged),
    .qx          (px),
    .qy          (py),
    .qz          (pz),
    .cand        (rd_data.box),
    .holds       (holds)
  );

  assign scan_more = (scan_idx < count);
  assign match     = (op_q == OP_QUERY) ? holds : (rd_data.key == key_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = count[AW-1:0];
    wr_data     = '{key: key_q, box: box_q};
    count_next  = count;
    done_next   = 1'b0;
    status_next = ST_DONE;
    hit_next    = 1'b0;
    key_next    = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_ADD: begin
              if (last_vertex) begin
                state_next = S_SCAN;
              end else begin
                done_next   = 1'b1;
                status_next = ST_BUFFERED;
              end
            end
            OP_REMOVE, OP_QUERY: begin
              state_next = S_SCAN;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en = scan_more;
        if (cmp_valid && match) begin
          case (op_q)
            OP_ADD: begin
              done_next   = 1'b1;
              status_next = ST_DUPLICATE;
              state_next  = S_IDLE;
            end
            OP_REMOVE: begin
              // The read of the next entry is already under way; the shift
              // pass continues that stream.
              state_next = S_SHIFT;
            end
            default: begin
              done_next  = 1'b1;
              hit_next   = 1'b1;
              key_next   = rd_data.key;
              state_next = S_IDLE;
            end
          endcase
        end else if (!cmp_valid && !scan_more) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          case (op_q)
            OP_ADD: begin
              if (count >= CW'(MAX_TILES)) begin
                status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_REMOVE: begin
              status_next = ST_NOT_FOUND;
            end
            default: begin
              status_next = ST_DONE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        rd_en = scan_more;
        if (cmp_valid) begin
          wr_en   = 1'b1;
          wr_addr = cmp_idx - AW'(1);
          wr_data = rd_data;
        end else if (!scan_more) begin
          count_next = count - CW'(1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[scan_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      scan_idx    <= '0;
      cmp_valid   <= 1'b0;
      pend_active <= 1'b0;
      pend_box    <= '0;
      done        <= 1'b0;
    end else begin
      count <= count_next;
      done  <= done_next;
      if (accept) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= rd_en;
        if (rd_en) begin
          scan_idx <= scan_idx + CW'(1);
        end
      end
      if (accept && op == OP_ADD) begin
        if (last_vertex) begin
          pend_active <= 1'b0;
          pend_box    <= '0;
        end else begin
          pend_active <= 1'b1;
          pend_box    <= merged;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    hit       <= hit_next;
    found_key <= key_next;
    if (rd_en) begin
      cmp_idx <= scan_idx[AW-1:0];
    end
    if (accept) begin
      op_q  <= op;
      key_q <= tile_key;
      px    <= coord_x;
      py    <= coord_y;
      pz    <= coord_z;
      box_q <= merged;
    end
  end

  // The table never holds more tiles than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TILES))
    else $error("tile count above table depth");

  // Every walk of the table ends with exactly one result word.
  a_walk_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("walk ended without a result");

  // A buffered vertex answers in the next cycle.
  a_vertex_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_ADD && !last_vertex) |=>
      (done && status == ST_BUFFERED))
    else $error("buffered vertex not answered");

  // A hit is only reported for a successful query.
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (status == ST_DONE))
    else $error("hit with error status");

  // The count moves by at most one per word, and only while walking.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(busy) &&
      (count == $past(count) + CW'(1) || count == $past(count) - CW'(1))))
    else $error("tile count jumped");

endmodule
